FILE: sv/lppd_pkg.sv
// Package for the length-prefixed packet deframer.
// Holds the result kinds, register indexes, header constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_MAX_PACKET_BYTES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIG_ENDIAN = 2'd1;

  localparam logic [15:0] MaxPacketBytesReset = 16'd4096;
  localparam logic [15:0] HeaderTotal = 16'd4;
  localparam logic [1:0] HeaderLastPos = 2'd3;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] packet_id;
    logic [7:0]  data;
    logic        last;
  } result_t;

  // One result handed from the parser to the result queue.
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  // Queue status seen by the parser and the output stage.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: sv/lppd_intf.sv
// Channel interfaces of the deframer: input bytes, results and register writes.
// Depends on lppd_pkg for the result kind type.
`timescale 1ns / 1ps
`default_nettype none

interface lppd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       restart;

  modport source (output valid, output stream_byte, output restart, input ready);
  modport sink (input valid, input stream_byte, input restart, output ready);
endinterface

interface lppd_result_if;
  logic                valid;
  logic                ready;
  lppd_pkg::kind_e     kind;
  logic [15:0]         packet_id;
  logic [7:0]          data;
  logic                last;

  modport source (output valid, output kind, output packet_id, output data, output last,
                  input ready);
  modport sink (input valid, input kind, input packet_id, input data, input last,
                output ready);
endinterface

interface lppd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lppd_pkg::CfgIdxW-1:0]  index;
  logic [lppd_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: sv/lppd_parser.sv
// Front part of the deframer: takes bytes, tracks header and body state and
// classifies each byte into at most one result. Holds the configuration registers.
// Depends on lppd_pkg and lppd_intf.
`timescale 1ns / 1ps
`default_nettype none

module lppd_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  lppd_byte_if.sink            in_i,
  lppd_cfg_if.sink             cfg_i,
  input  lppd_pkg::q_stat_t    q_stat_i,
  output lppd_pkg::push_t      push_o
);

  logic [15:0] max_bytes_q, max_bytes_d;
  logic        big_endian_q, big_endian_d;

  logic [1:0]  hdr_pos_q, hdr_pos_d;
  logic [23:0] hdr_bytes_q, hdr_bytes_d;
  logic [15:0] body_rem_q, body_rem_d;
  logic [15:0] cur_id_q, cur_id_d;
  logic        halt_q, halt_d;

  logic        in_xfer;
  logic        cfg_xfer;
  logic [15:0] size;
  logic [15:0] id;

  // Every byte yields at most one result, so one free queue slot is enough.
  assign in_i.ready = ~q_stat_i.full;
  assign cfg_i.ready = 1'b1;
  assign in_xfer = in_i.valid & in_i.ready;
  assign cfg_xfer = cfg_i.valid;

  always_comb begin
    max_bytes_d = max_bytes_q;
    big_endian_d = big_endian_q;
    if (cfg_xfer) begin
      case (cfg_i.index)
        lppd_pkg::CFG_MAX_PACKET_BYTES: max_bytes_d = cfg_i.wdata;
        lppd_pkg::CFG_BIG_ENDIAN:       big_endian_d = cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (big_endian_q) begin
      size = {hdr_bytes_q[7:0], hdr_bytes_q[15:8]};
      id = {hdr_bytes_q[23:16], in_i.stream_byte};
    end else begin
      size = {hdr_bytes_q[15:8], hdr_bytes_q[7:0]};
      id = {in_i.stream_byte, hdr_bytes_q[23:16]};
    end
  end

  always_comb begin
    hdr_pos_d = hdr_pos_q;
    hdr_bytes_d = hdr_bytes_q;
    body_rem_d = body_rem_q;
    cur_id_d = cur_id_q;
    halt_d = halt_q;
    push_o.valid = 1'b0;
    push_o.res.kind = lppd_pkg::KIND_BODY;
    push_o.res.packet_id = cur_id_q;
    push_o.res.data = in_i.stream_byte;
    push_o.res.last = 1'b0;
    if (in_xfer) begin
      if (in_i.restart) begin
        hdr_pos_d = '0;
        hdr_bytes_d = '0;
        body_rem_d = '0;
        cur_id_d = '0;
        halt_d = 1'b0;
      end else if (halt_q) begin
        hdr_pos_d = hdr_pos_q;
      end else if (body_rem_q != 16'd0) begin
        body_rem_d = body_rem_q - 16'd1;
        push_o.valid = 1'b1;
        push_o.res.last = (body_rem_q == 16'd1);
      end else if (hdr_pos_q != lppd_pkg::HeaderLastPos) begin
        hdr_bytes_d[{hdr_pos_q, 3'b000} +: 8] = in_i.stream_byte;
        hdr_pos_d = hdr_pos_q + 2'd1;
      end else begin
        // Fourth header byte: the whole header is known now.
        hdr_pos_d = '0;
        hdr_bytes_d = '0;
        push_o.res.packet_id = id;
        push_o.res.data = 8'd0;
        push_o.res.last = 1'b1;
        if (size < lppd_pkg::HeaderTotal || size > max_bytes_q) begin
          halt_d = 1'b1;
          push_o.valid = 1'b1;
          push_o.res.kind = lppd_pkg::KIND_ERROR;
        end else if (size == lppd_pkg::HeaderTotal) begin
          push_o.valid = 1'b1;
          push_o.res.kind = lppd_pkg::KIND_EMPTY;
        end else begin
          cur_id_d = id;
          body_rem_d = size - lppd_pkg::HeaderTotal;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= lppd_pkg::MaxPacketBytesReset;
      big_endian_q <= 1'b0;
      hdr_pos_q <= '0;
      hdr_bytes_q <= '0;
      body_rem_q <= '0;
      cur_id_q <= '0;
      halt_q <= 1'b0;
    end else begin
      max_bytes_q <= max_bytes_d;
      big_endian_q <= big_endian_d;
      hdr_pos_q <= hdr_pos_d;
      hdr_bytes_q <= hdr_bytes_d;
      body_rem_q <= body_rem_d;
      cur_id_q <= cur_id_d;
      halt_q <= halt_d;
    end
  end

`ifndef SYNTHESIS
  // Once halted, only a restart transfer may clear the halt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q && !(in_xfer && in_i.restart) |=> halt_q)
    else $error("halt cleared without restart");

  // A body byte counts the remaining body down by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !in_i.restart && !halt_q && body_rem_q != 16'd0
      |=> body_rem_q == $past(body_rem_q) - 16'd1)
    else $error("body count did not step down");

  // Header bytes are only gathered outside the body phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    body_rem_q != 16'd0 |-> hdr_pos_q == 2'd0)
    else $error("header position moved during body");
`endif

endmodule

`default_nettype wire

FILE: sv/lppd_queue.sv
// Two-entry result queue between the parser and the output stage.
// Depends on lppd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lppd_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lppd_pkg::push_t      push_i,
  input  wire                  pop_i,
  output lppd_pkg::result_t    pop_data_o,
  output lppd_pkg::q_stat_t    q_stat_o
);

  lppd_pkg::result_t mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign q_stat_o.full = (cnt_q == 2'd2);
  assign q_stat_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i.valid & ~q_stat_o.full;
  assign do_pop = pop_i & ~q_stat_o.empty;
  assign pop_data_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  // The parser never offers a result when no slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !q_stat_o.full)
    else $error("push into full queue");

  // Fill level and pointer distance agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers and count disagree");
`endif

endmodule

`default_nettype wire

FILE: sv/lppd_out_stage.sv
// Back part of the deframer: output register that moves queued results onto
// the result channel. Depends on lppd_pkg and lppd_intf.
`timescale 1ns / 1ps
`default_nettype none

module lppd_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lppd_pkg::q_stat_t    q_stat_i,
  input  lppd_pkg::result_t    pop_data_i,
  output logic                 pop_o,
  lppd_result_if.source        out_o
);

  logic              out_valid_q, out_valid_d;
  lppd_pkg::result_t out_res_q, out_res_d;
  logic              load;

  // The register refills whenever it is empty or its content is taken.
  assign load = ~out_valid_q | out_o.ready;
  assign pop_o = load & ~q_stat_i.empty;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d = out_res_q;
    if (load) begin
      out_valid_d = ~q_stat_i.empty;
      out_res_d = pop_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.kind = out_res_q.kind;
  assign out_o.packet_id = out_res_q.packet_id;
  assign out_o.data = out_res_q.data;
  assign out_o.last = out_res_q.last;

endmodule

`default_nettype wire

FILE: sv/length_prefixed_packet_deframer_core.sv
// Length-prefixed packet deframer: takes one stream byte per cycle and emits
// at most one result per byte, so it sustains one byte per clock cycle when the
// result side keeps up. The edge that takes a byte writes its result into the
// two-entry result queue; from there it moves into the output register, which
// offers it on the result channel. When the result side stalls, the input takes
// bytes until the output register and the queue hold three results.
// Packets start with a 4-byte header (16-bit total size including the header,
// then 16-bit id, byte order set by register 1); register 0 sets the largest
// accepted size. Size and byte order are sampled on the fourth header byte. An
// invalid size gives one error result and then bytes are dropped until a
// restart transfer. Register writes are always taken and belong in idle time.
// Depends on lppd_pkg, lppd_intf, lppd_parser, lppd_queue and lppd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_packet_deframer_core (
  input  wire            clk_i,
  input  wire            rst_ni,
  lppd_byte_if.sink      in_i,
  lppd_cfg_if.sink       cfg_i,
  lppd_result_if.source  out_o
);

  lppd_pkg::push_t   push;
  lppd_pkg::q_stat_t q_stat;
  lppd_pkg::result_t pop_data;
  logic              pop;

  lppd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  lppd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .q_stat_o   (q_stat)
  );

  lppd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

FILE: verif/length_prefixed_packet_deframer_core_test.sv
// Self-checking testbench for length_prefixed_packet_deframer_core: drives framed byte
// streams with random gaps and stalls and checks every result against a deframing predictor.
// Depends on lppd_pkg, lppd_intf and the deframer RTL.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_core_test;

  localparam logic [lppd_pkg::CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [lppd_pkg::CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;
  localparam int SettleCycles = 4;
  localparam int HoldOffCycles = 150;
  localparam int DrainGuard = 5000;

  logic clk;
  logic rst_n;
  logic rx_hold;

  lppd_byte_if   byte_ch ();
  lppd_result_if res_ch ();
  lppd_cfg_if    cfg_ch ();

  length_prefixed_packet_deframer_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .cfg_i  (cfg_ch),
    .out_o  (res_ch)
  );

  // Predictor copy of the registers and the parser state.
  logic [15:0] max_bytes_reg;
  logic        big_endian_reg;
  logic [2:0]  hdr_pos;
  logic [23:0] hdr_bytes;
  logic [15:0] body_left;
  logic [15:0] cur_id;
  logic        halted;

  lppd_pkg::result_t due_results[$];
  int fault_count;
  int items_sent;
  int in_gap_max;
  int out_gap_max;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("length_prefixed_packet_deframer_core_test: errors");
    $finish;
  end

  function automatic void clear_parser();
    hdr_pos = '0;
    hdr_bytes = '0;
    body_left = '0;
    cur_id = '0;
    halted = 1'b0;
  endfunction

  function automatic void post_result(lppd_pkg::kind_e k, logic [15:0] id, logic [7:0] d,
                                      logic l);
    lppd_pkg::result_t r;
    r.kind = k;
    r.packet_id = id;
    r.data = d;
    r.last = l;
    due_results.insert(due_results.size(), r);
  endfunction

  // Advances the predicted parser by one accepted byte.
  function automatic void deframe_byte(input logic [7:0] b, input logic rs);
    logic [15:0] size;
    logic [15:0] id;
    if (rs) begin
      clear_parser();
    end else if (!halted) begin
      if (body_left != 0) begin
        body_left = body_left - 16'd1;
        post_result(lppd_pkg::KIND_BODY, cur_id, b, body_left == 0);
      end else if (hdr_pos < 3'(lppd_pkg::HeaderLastPos)) begin
        hdr_bytes[8*hdr_pos +: 8] = b;
        hdr_pos = hdr_pos + 3'd1;
      end else begin
        size = big_endian_reg ? {hdr_bytes[7:0], hdr_bytes[15:8]} : hdr_bytes[15:0];
        id = big_endian_reg ? {hdr_bytes[23:16], b} : {b, hdr_bytes[23:16]};
        hdr_pos = '0;
        hdr_bytes = '0;
        if (size < lppd_pkg::HeaderTotal || size > max_bytes_reg) begin
          halted = 1'b1;
          post_result(lppd_pkg::KIND_ERROR, id, 8'h00, 1'b1);
        end else if (size == lppd_pkg::HeaderTotal) begin
          post_result(lppd_pkg::KIND_EMPTY, id, 8'h00, 1'b1);
        end else begin
          cur_id = id;
          body_left = size - lppd_pkg::HeaderTotal;
        end
      end
    end
  endfunction

  task automatic check_result();
    lppd_pkg::result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: kind %0d id %0d data %0d last %0d",
             res_ch.kind, res_ch.packet_id, res_ch.data, res_ch.last);
      fault_count++;
    end else begin
      want = due_results[0];
      due_results.delete(0);
      if (res_ch.kind !== want.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", want.kind, res_ch.kind);
        fault_count++;
      end
      if (res_ch.packet_id !== want.packet_id) begin
        $error("packet_id mismatch: expected %0d, actual %0d", want.packet_id,
               res_ch.packet_id);
        fault_count++;
      end
      if (res_ch.data !== want.data) begin
        $error("data mismatch: expected %0d, actual %0d", want.data, res_ch.data);
        fault_count++;
      end
      if (res_ch.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, res_ch.last);
        fault_count++;
      end
    end
  endtask

  // Result side: checks each transfer, then stalls for a random number of cycles.
  initial begin
    int stall;
    stall = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        check_result();
        stall = $urandom_range(0, out_gap_max);
      end
      if (rx_hold || stall > 0) begin
        res_ch.ready <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Valid stays high from one byte to the next when no gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.stream_byte <= b;
    byte_ch.restart <= rs;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    deframe_byte(b, rs);
    items_sent++;
  endtask

  task automatic send_header(input logic [15:0] size, input logic [15:0] id);
    if (big_endian_reg) begin
      send_byte(size[15:8], 1'b0);
      send_byte(size[7:0], 1'b0);
      send_byte(id[15:8], 1'b0);
      send_byte(id[7:0], 1'b0);
    end else begin
      send_byte(size[7:0], 1'b0);
      send_byte(size[15:8], 1'b0);
      send_byte(id[7:0], 1'b0);
      send_byte(id[15:8], 1'b0);
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    byte_ch.valid <= 1'b0;
    while (due_results.size() != 0 && guard < DrainGuard) begin
      @(posedge clk);
      guard++;
    end
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      fault_count += due_results.size();
      due_results.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [lppd_pkg::CfgIdxW-1:0] idx,
                         input logic [lppd_pkg::CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == lppd_pkg::CFG_MAX_PACKET_BYTES) max_bytes_reg = val;
    else if (idx == lppd_pkg::CFG_BIG_ENDIAN) big_endian_reg = val[0];
  endtask

  // Writes to the unused indexes must leave both registers alone.
  task automatic set_regs(input logic [15:0] max_bytes, input logic [15:0] order_word);
    cfg_put(CfgIdxSpareLo, 16'($urandom));
    cfg_put(lppd_pkg::CFG_MAX_PACKET_BYTES, max_bytes);
    cfg_put(lppd_pkg::CFG_BIG_ENDIAN, order_word);
    cfg_put(CfgIdxSpareHi, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    // Reset defaults: 4096-byte limit, little-endian header.
    send_header(16'd5, 16'hFFFF);
    send_byte(8'hFF, 1'b0);
    send_header(lppd_pkg::HeaderTotal, 16'h0000);
    send_header(16'd4097, 16'h1234);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
    // Big-endian with junk in the upper register bits; size equal to the limit, then one over.
    set_regs(16'd6, 16'hFFFF);
    send_header(16'd6, 16'h8001);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_header(16'd7, 16'h7FFE);
    send_byte(8'hFF, 1'b1);
    send_header(16'd3, 16'h00FF);
    send_byte(8'h5A, 1'b1);
    wait_idle();
  endtask

  // Mostly well-formed packets; the rest are bad sizes, noise and cut-off packets.
  task automatic random_traffic(input int n);
    int stop_at;
    int pick;
    int room;
    int cap;
    int body_len;
    logic [15:0] size;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      room = int'(max_bytes_reg) - int'(lppd_pkg::HeaderTotal);
      cap = (room > 12) ? 12 : room;
      pick = $urandom_range(0, 99);
      if (halted) begin
        send_byte(8'($urandom), ($urandom_range(0, 3) != 0));
      end else if (pick < 70) begin
        if (pick < 4 && room <= 60) body_len = room;
        else if (pick < 10) body_len = $urandom_range(0, (room > 60) ? 60 : room);
        else body_len = $urandom_range(0, cap);
        send_header(16'(body_len + int'(lppd_pkg::HeaderTotal)), 16'($urandom));
        repeat (body_len) send_byte(8'($urandom), 1'b0);
      end else if (pick < 80) begin
        if (max_bytes_reg == 16'hFFFF || $urandom_range(0, 1) == 0)
          size = 16'($urandom_range(0, int'(lppd_pkg::HeaderTotal) - 1));
        else
          size = 16'($urandom_range(int'(max_bytes_reg) + 1, 65535));
        send_header(size, 16'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end else if (cap > 1 && $urandom_range(0, 1) == 0) begin
        body_len = $urandom_range(2, cap);
        send_header(16'(body_len + int'(lppd_pkg::HeaderTotal)), 16'($urandom));
        repeat ($urandom_range(1, body_len - 1)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
    end
    if (halted) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random_phase(input logic [15:0] max_bytes, input logic [15:0] order_word,
                                   input int n, input int gap_in, input int gap_out);
    set_regs(max_bytes, order_word);
    in_gap_max = gap_in;
    out_gap_max = gap_out;
    random_traffic(n);
    wait_idle();
  endtask

  // The result side holds off while bytes keep coming, so the result queue fills up.
  task automatic test_backpressure();
    set_regs(16'd64, 16'h0000);
    in_gap_max = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        send_header(16'd40, 16'($urandom));
        repeat (36) send_byte(8'($urandom), 1'b0);
      end
    join
    wait_idle();
    in_gap_max = 10;
  endtask

  initial begin
    rst_n <= 1'b0;
    rx_hold <= 1'b0;
    byte_ch.valid <= 1'b0;
    byte_ch.stream_byte <= '0;
    byte_ch.restart <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.wdata <= '0;
    max_bytes_reg = lppd_pkg::MaxPacketBytesReset;
    big_endian_reg = 1'b0;
    clear_parser();
    fault_count = 0;
    items_sent = 0;
    in_gap_max = 10;
    out_gap_max = 10;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phase(lppd_pkg::HeaderTotal, 16'h0000, 60, 10, 10);
    test_random_phase(16'hFFFF, 16'h0001, 200, 10, 3);
    test_backpressure();
    test_random_phase(16'($urandom_range(4, 80)), 16'($urandom), 200, 0, 0);
    test_random_phase(lppd_pkg::MaxPacketBytesReset, 16'($urandom), 200, 3, 10);

    if (fault_count == 0) begin
      $display("length_prefixed_packet_deframer_core_test: clean");
    end else begin
      $display("length_prefixed_packet_deframer_core_test: errors");
    end
    $finish;
  end

endmodule
